### sv/clpws_pkg.sv
package clpws_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W = 16;
  localparam int STEP_W = 4;

  // Operation codes on the input channel.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CMD   = 2'd1,
    OP_DATA  = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_UP_WAIT  = 3'd0,
    REG_SECOND_WAKE    = 3'd1,
    REG_STEP_WAIT      = 3'd2,
    REG_POST_WRITE     = 3'd3,
    REG_STROBE_PHASE   = 3'd4,
    REG_FUNCTION_SET   = 3'd5,
    REG_ENTRY_MODE     = 3'd6,
    REG_DISPLAY_CTRL   = 3'd7
  } reg_idx_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SETUP  = 7'b0000010,
    PH_PLACE  = 7'b0000100,
    PH_EHIGH  = 7'b0001000,
    PH_ELOW   = 7'b0010000,
    PH_SETTLE = 7'b0100000,
    PH_WAIT   = 7'b1000000
  } phase_t;

  localparam logic [TIME_W-1:0] POWER_UP_WAIT_RST = 16'd20000;
  localparam logic [TIME_W-1:0] SECOND_WAKE_RST   = 16'd5000;
  localparam logic [TIME_W-1:0] STEP_WAIT_RST     = 16'd100;
  localparam logic [TIME_W-1:0] POST_WRITE_RST    = 16'd3000;
  localparam logic [7:0]        STROBE_PHASE_RST  = 8'd1;
  localparam logic [7:0]        FUNCTION_SET_RST  = 8'h38;
  localparam logic [7:0]        ENTRY_MODE_RST    = 8'h06;
  localparam logic [7:0]        DISPLAY_CTRL_RST  = 8'h0F;

  localparam logic [7:0] CMD_WAKE  = 8'h30;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  // Init steps: the wake commands run for steps 1 to 3.
  localparam logic [STEP_W-1:0] STEP_FIRST_WAKE = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FUNC_SET   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ENTRY_MODE = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CLEAR      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DISPLAY    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LAST       = 4'd7;

  typedef struct packed {
    logic       register_select;
    logic       read_write;
    logic       enable_pin;
    logic [7:0] bus_byte;
    logic       busy_res;
    logic       request_refused;
    logic       init_done;
  } res_t;

endpackage

### sv/clpws_if.sv
interface clpws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface clpws_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic       read_write;
  logic       enable_pin;
  logic [7:0] bus_byte;
  logic       busy_res;
  logic       request_refused;
  logic       init_done;

  modport source (output valid, output register_select, output read_write,
                  output enable_pin, output bus_byte, output busy_res,
                  output request_refused, output init_done, input ready);
  modport sink   (input valid, input register_select, input read_write,
                  input enable_pin, input bus_byte, input busy_res,
                  input request_refused, input init_done, output ready);
endinterface

### sv/char_lcd_parallel_write_sequencer_top.sv
// Sequencer for an 8-bit character LCD bus. Every input transfer is a one-microsecond
// tick, a command write, a data write or an init start, and it yields exactly one result
// transfer that shows the pin levels and status after that item. One item is taken in
// every cycle while the skid entry is empty; its result goes to the output register, or
// to that entry while the result side stalls, in a two-entry output buffer. Requests
// that arrive while a write or the init sequence is running are dropped and flagged in
// request_refused. Configuration writes are meant for idle periods only.
module char_lcd_parallel_write_sequencer_top #(
  parameter int TIMER_BITS = clpws_pkg::TIMER_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  clpws_in_if.sink                              in_ch,
  clpws_out_if.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [clpws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clpws_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  // Configuration registers.
  logic [clpws_pkg::TIME_W-1:0] power_up_wait_r, second_wake_r, step_wait_r, post_write_r;
  logic [7:0] strobe_phase_r, function_set_r, entry_mode_r, display_ctrl_r;

  // Sequencer state.
  clpws_pkg::phase_t             phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]         countdown_r, countdown_nxt;
  logic [clpws_pkg::STEP_W-1:0]  init_step_r, init_step_nxt;
  logic                          in_init_r, in_init_nxt;
  logic                          sel_r, sel_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic                          init_fin_r, init_fin_nxt;

  // Output buffer.
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  clpws_pkg::res_t   out_data_r, skid_data_r, res;

  logic              in_fire;
  logic              out_take;
  logic [TIMER_BITS-1:0] count_dec;
  logic [clpws_pkg::STEP_W-1:0] step_inc;
  logic [7:0]        init_byte;

  function automatic logic [TIMER_BITS-1:0] sat_len(input logic [clpws_pkg::TIME_W-1:0] len);
    logic [32:0] wide;
    wide = {{(33-clpws_pkg::TIME_W){1'b0}}, len};
    if (wide > TMAX) begin
      sat_len = TMAX[TIMER_BITS-1:0];
    end else begin
      sat_len = wide[TIMER_BITS-1:0];
    end
  endfunction

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_take    = !out_valid_r || out_ch.ready;

  assign count_dec = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;
  assign step_inc  = init_step_r + 1'b1;

  // Byte for the init write that starts at the incremented step.
  always_comb begin
    case (step_inc)
      clpws_pkg::STEP_FUNC_SET:   init_byte = function_set_r;
      clpws_pkg::STEP_ENTRY_MODE: init_byte = entry_mode_r;
      clpws_pkg::STEP_CLEAR:      init_byte = clpws_pkg::CMD_CLEAR;
      clpws_pkg::STEP_DISPLAY:    init_byte = display_ctrl_r;
      default:                    init_byte = clpws_pkg::CMD_WAKE;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    init_step_nxt = init_step_r;
    in_init_nxt   = in_init_r;
    sel_nxt       = sel_r;
    byte_nxt      = byte_r;
    init_fin_nxt  = init_fin_r;
    res.request_refused = 1'b0;

    if (in_fire) begin
      if (in_ch.operation == clpws_pkg::OP_TICK) begin
        if (phase_r != clpws_pkg::PH_IDLE) begin
          countdown_nxt = count_dec;
          if (count_dec == '0) begin
            case (phase_r)
              clpws_pkg::PH_SETUP: begin
                phase_nxt     = clpws_pkg::PH_PLACE;
                countdown_nxt = sat_len({8'd0, strobe_phase_r});
              end
              clpws_pkg::PH_PLACE: begin
                phase_nxt     = clpws_pkg::PH_EHIGH;
                countdown_nxt = sat_len({8'd0, strobe_phase_r});
              end
              clpws_pkg::PH_EHIGH: begin
                phase_nxt     = clpws_pkg::PH_ELOW;
                countdown_nxt = sat_len({8'd0, strobe_phase_r});
              end
              clpws_pkg::PH_ELOW: begin
                phase_nxt     = clpws_pkg::PH_SETTLE;
                countdown_nxt = sat_len(post_write_r);
              end
              clpws_pkg::PH_SETTLE: begin
                if (in_init_r) begin
                  phase_nxt     = clpws_pkg::PH_WAIT;
                  countdown_nxt = sat_len((init_step_r == clpws_pkg::STEP_FIRST_WAKE) ?
                                          second_wake_r : step_wait_r);
                end else begin
                  phase_nxt     = clpws_pkg::PH_IDLE;
                  countdown_nxt = '0;
                end
              end
              clpws_pkg::PH_WAIT: begin
                if (in_init_r && (init_step_r < clpws_pkg::STEP_LAST)) begin
                  init_step_nxt = step_inc;
                  sel_nxt       = 1'b0;
                  byte_nxt      = init_byte;
                  phase_nxt     = clpws_pkg::PH_SETUP;
                  countdown_nxt = sat_len({8'd0, strobe_phase_r});
                end else begin
                  in_init_nxt   = 1'b0;
                  init_fin_nxt  = 1'b1;
                  init_step_nxt = '0;
                  phase_nxt     = clpws_pkg::PH_IDLE;
                  countdown_nxt = '0;
                end
              end
              default: begin
                phase_nxt     = clpws_pkg::PH_IDLE;
                countdown_nxt = '0;
              end
            endcase
          end
        end
      end else if (phase_r != clpws_pkg::PH_IDLE) begin
        res.request_refused = 1'b1;
      end else if (in_ch.operation == clpws_pkg::OP_INIT) begin
        in_init_nxt   = 1'b1;
        init_fin_nxt  = 1'b0;
        init_step_nxt = '0;
        phase_nxt     = clpws_pkg::PH_WAIT;
        countdown_nxt = sat_len(power_up_wait_r);
      end else begin
        sel_nxt       = (in_ch.operation == clpws_pkg::OP_DATA);
        byte_nxt      = in_ch.byte_value;
        phase_nxt     = clpws_pkg::PH_SETUP;
        countdown_nxt = sat_len({8'd0, strobe_phase_r});
      end
    end

    res.register_select = sel_nxt && ((phase_nxt == clpws_pkg::PH_SETUP) ||
                                      (phase_nxt == clpws_pkg::PH_PLACE) ||
                                      (phase_nxt == clpws_pkg::PH_EHIGH) ||
                                      (phase_nxt == clpws_pkg::PH_ELOW));
    res.read_write = 1'b0;
    res.enable_pin = (phase_nxt == clpws_pkg::PH_EHIGH);
    res.bus_byte   = byte_nxt;
    res.busy_res   = (phase_nxt != clpws_pkg::PH_IDLE);
    res.init_done  = init_fin_nxt;
  end

  // The skid entry is only filled while the output register is stalled.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= clpws_pkg::PH_IDLE;
      countdown_r  <= '0;
      init_step_r  <= '0;
      in_init_r    <= 1'b0;
      sel_r        <= 1'b0;
      byte_r       <= '0;
      init_fin_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      countdown_r  <= countdown_nxt;
      init_step_r  <= init_step_nxt;
      in_init_r    <= in_init_nxt;
      sel_r        <= sel_nxt;
      byte_r       <= byte_nxt;
      init_fin_r   <= init_fin_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_up_wait_r <= clpws_pkg::POWER_UP_WAIT_RST;
      second_wake_r   <= clpws_pkg::SECOND_WAKE_RST;
      step_wait_r     <= clpws_pkg::STEP_WAIT_RST;
      post_write_r    <= clpws_pkg::POST_WRITE_RST;
      strobe_phase_r  <= clpws_pkg::STROBE_PHASE_RST;
      function_set_r  <= clpws_pkg::FUNCTION_SET_RST;
      entry_mode_r    <= clpws_pkg::ENTRY_MODE_RST;
      display_ctrl_r  <= clpws_pkg::DISPLAY_CTRL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        clpws_pkg::REG_POWER_UP_WAIT: power_up_wait_r <= cfg_wdata;
        clpws_pkg::REG_SECOND_WAKE:   second_wake_r   <= cfg_wdata;
        clpws_pkg::REG_STEP_WAIT:     step_wait_r     <= cfg_wdata;
        clpws_pkg::REG_POST_WRITE:    post_write_r    <= cfg_wdata;
        clpws_pkg::REG_STROBE_PHASE:  strobe_phase_r  <= cfg_wdata[7:0];
        clpws_pkg::REG_FUNCTION_SET:  function_set_r  <= cfg_wdata[7:0];
        clpws_pkg::REG_ENTRY_MODE:    entry_mode_r    <= cfg_wdata[7:0];
        clpws_pkg::REG_DISPLAY_CTRL:  display_ctrl_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.register_select = out_data_r.register_select;
  assign out_ch.read_write      = out_data_r.read_write;
  assign out_ch.enable_pin      = out_data_r.enable_pin;
  assign out_ch.bus_byte        = out_data_r.bus_byte;
  assign out_ch.busy_res        = out_data_r.busy_res;
  assign out_ch.request_refused = out_data_r.request_refused;
  assign out_ch.init_done       = out_data_r.init_done;

endmodule

### sv/clpws_checker.sv
module clpws_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       register_select,
  input logic       read_write,
  input logic       enable_pin,
  input logic [7:0] bus_byte,
  input logic       busy_res,
  input logic       request_refused
);

  // The bus is only ever written.
  a_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !read_write)
    else $error("read_write asserted on a result");

  // The strobe and RS only rise inside a running write.
  a_pins_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (enable_pin || register_select) |-> busy_res)
    else $error("E or RS active while idle");

  // A refusal leaves the block busy with the earlier work.
  a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && request_refused |-> busy_res)
    else $error("request refused while idle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bus_byte) && $stable(enable_pin))
    else $error("stalled result changed");

endmodule

bind char_lcd_parallel_write_sequencer_top clpws_checker u_clpws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .register_select (out_ch.register_select),
  .read_write      (out_ch.read_write),
  .enable_pin      (out_ch.enable_pin),
  .bus_byte        (out_ch.bus_byte),
  .busy_res        (out_ch.busy_res),
  .request_refused (out_ch.request_refused)
);
